FILE: hdl/bmg_pkg.sv
`default_nettype none
package bmg_pkg;

    localparam int UNIFORM_BITS     = 16;
    localparam int OUT_FRAC_BITS_DF = 12;
    localparam int LOG_FRAC_BITS    = 24;
    localparam int SQRT_STEPS       = 32;

    // stage counts after the input register; PIPE_LAST counts from the accepting edge
    localparam int RAD_LAT   = 1 + LOG_FRAC_BITS + 2 + SQRT_STEPS;
    localparam int TRIG_LAT  = 18;
    localparam int PIPE_LAST = RAD_LAT + 3;

    localparam logic [63:0] Q30_ONE  = 64'd1 << 30;
    localparam logic [30:0] LN2X2    = 31'd1488522236;
    localparam logic [31:0] PI_Q30   = 32'd3373259426;

    // Horner divisors and 2^32/d reciprocals
    localparam logic [6:0]  COS_DIV [5] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
    localparam logic [6:0]  SIN_DIV [4] = '{7'd72, 7'd42, 7'd20, 7'd6};
    localparam logic [31:0] COS_RCP [5] = '{
        32'((64'd1 << 32) / 90), 32'((64'd1 << 32) / 56), 32'((64'd1 << 32) / 30),
        32'((64'd1 << 32) / 12), 32'((64'd1 << 32) / 2)};
    localparam logic [31:0] SIN_RCP [4] = '{
        32'((64'd1 << 32) / 72), 32'((64'd1 << 32) / 42), 32'((64'd1 << 32) / 20),
        32'((64'd1 << 32) / 6)};

    typedef struct packed {
        logic [UNIFORM_BITS-1:0] uniform_radius;
        logic [UNIFORM_BITS-1:0] uniform_angle;
    } t_in_word;

    typedef struct packed {
        logic               accepted;
        logic signed [15:0] normal_cos;
        logic signed [15:0] normal_sin;
    } t_out_word;

    typedef struct packed {
        logic [30:0] tc;
        logic [30:0] ts;
        logic        negc;
        logic        negs;
    } t_trig;

endpackage
`default_nettype wire

FILE: hdl/box_muller_gaussian_pair.sv
// Box-Muller pair generator, fully pipelined.
// Throughput: one uniform pair per cycle; busy never rises, the receiver cannot stall.
// Depth: the 24-stage log2 squaring chain and the 32-stage square root set the
// pipeline depth from the edge that takes start to the edge that takes the word.
// Reset (synchronous, active low) clears only the valid pipeline.
`default_nettype none
module box_muller_gaussian_pair
    import bmg_pkg::*;
#(
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_in_word i_word,
    output logic      o_strobe,
    output t_out_word o_word
);

    localparam int SH = 54 - OUT_FRAC_BITS;
    localparam int DLY = RAD_LAT - TRIG_LAT;

    logic [PIPE_LAST-1:0] r_vld;
    logic [PIPE_LAST-2:0] r_ok;
    t_in_word             r_in;
    logic [31:0]          w_radius;
    t_trig                w_trig;
    t_trig                r_tdl [DLY];
    logic [62:0]          r_pc;
    logic [62:0]          r_ps;
    logic                 r_negc;
    logic                 r_negs;
    t_out_word            r_out;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_LAST-2:0], start & ~busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= i_word;
        r_ok <= {r_ok[PIPE_LAST-3:0],
                 (i_word.uniform_radius != '0) && (i_word.uniform_angle != '0)};
    end

    bmg_radius u_radius (
        .i_clk    (i_clk),
        .i_code   (r_in.uniform_radius),
        .o_radius (w_radius)
    );

    bmg_trig u_trig (
        .i_clk  (i_clk),
        .i_code (r_in.uniform_angle),
        .o_trig (w_trig)
    );

    always_ff @(posedge i_clk) begin
        r_tdl[0] <= w_trig;
        for (int s = 1; s < DLY; s++) r_tdl[s] <= r_tdl[s-1];
        r_pc   <= 63'(w_radius) * 63'(r_tdl[DLY-1].tc);
        r_ps   <= 63'(w_radius) * 63'(r_tdl[DLY-1].ts);
        r_negc <= r_tdl[DLY-1].negc;
        r_negs <= r_tdl[DLY-1].negs;
    end

    function automatic logic [15:0] scale_out(input logic [62:0] prod, input logic neg);
        logic [63:0] mag;
        mag = (64'(prod) + (64'd1 << (SH-1))) >> SH;
        if (neg) begin
            scale_out = (mag >= 64'd32768) ? 16'h8000 : 16'(64'd0 - mag);
        end else begin
            scale_out = (mag > 64'd32767) ? 16'h7FFF : mag[15:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (r_ok[PIPE_LAST-2]) begin
            r_out.accepted   <= 1'b1;
            r_out.normal_cos <= scale_out(r_pc, r_negc);
            r_out.normal_sin <= scale_out(r_ps, r_negs);
        end else begin
            r_out.accepted   <= 1'b0;
            r_out.normal_cos <= '0;
            r_out.normal_sin <= '0;
        end
    end

    assign o_strobe = r_vld[PIPE_LAST-1];
    assign o_word   = r_out;

`ifndef ASSERT_OFF
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, PIPE_LAST))
        else $error("strobe without a matching start");
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_word.accepted) |-> (o_word.normal_cos == 0 && o_word.normal_sin == 0))
        else $error("rejected word carries nonzero samples");
    a_accept_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_word.accepted) |->
            $past(i_word.uniform_radius != 0 && i_word.uniform_angle != 0, PIPE_LAST))
        else $error("accepted word from a zero uniform");
`endif

endmodule
`default_nettype wire

FILE: hdl/bmg_radius.sv
`default_nettype none
module bmg_radius
    import bmg_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic [UNIFORM_BITS-1:0] i_code,
    output logic [31:0]                  o_radius
);

    logic [4:0]  n_e;
    logic [4:0]  r_e  [LOG_FRAC_BITS+1];
    logic [30:0] r_m  [LOG_FRAC_BITS+1];
    logic [23:0] r_fr [LOG_FRAC_BITS+1];
    logic [60:0] r_p;
    logic [63:0] r_n0;
    logic [63:0] r_sn [SQRT_STEPS];
    logic [63:0] r_sr [SQRT_STEPS];

    // leading one position
    always_comb begin
        n_e = '0;
        for (int k = 1; k < UNIFORM_BITS; k++) begin
            if (i_code[k]) begin
                n_e = 5'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_e[0]  <= n_e;
        r_m[0]  <= 31'(({30'd0, i_code} << 30) >> n_e);
        r_fr[0] <= '0;
    end

    // one log2 fraction bit per stage by squaring the mantissa
    for (genvar i = 0; i < LOG_FRAC_BITS; i++) begin : g_log
        logic [61:0] w_sq;
        logic [31:0] w_s;
        assign w_sq = 62'(r_m[i]) * 62'(r_m[i]);
        assign w_s  = 32'(w_sq >> 30);
        always_ff @(posedge i_clk) begin
            r_e[i+1] <= r_e[i];
            if (w_s[31]) begin
                r_m[i+1]  <= w_s[31:1];
                r_fr[i+1] <= r_fr[i] | (24'd1 << (LOG_FRAC_BITS-1-i));
            end else begin
                r_m[i+1]  <= w_s[30:0];
                r_fr[i+1] <= r_fr[i];
            end
        end
    end

    logic [28:0] w_l;
    assign w_l = 29'((29'(UNIFORM_BITS) << LOG_FRAC_BITS)
                     - ((29'(r_e[LOG_FRAC_BITS]) << LOG_FRAC_BITS)
                        + 29'(r_fr[LOG_FRAC_BITS])));

    always_ff @(posedge i_clk) begin
        r_p  <= 61'(w_l) * 61'(LN2X2);
        r_n0 <= 64'(((64'(r_p) + (64'd1 << 29)) >> 30) << 24);
    end

    // bit-serial square root, one root bit per stage
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        localparam logic [63:0] B = 64'd1 << (62 - 2*j);
        logic [63:0] w_n;
        logic [63:0] w_r;
        assign w_n = (j == 0) ? r_n0 : r_sn[(j == 0) ? 0 : j-1];
        assign w_r = (j == 0) ? 64'd0 : r_sr[(j == 0) ? 0 : j-1];
        always_ff @(posedge i_clk) begin
            if (w_n >= w_r + B) begin
                r_sn[j] <= w_n - (w_r + B);
                r_sr[j] <= (w_r >> 1) + B;
            end else begin
                r_sn[j] <= w_n;
                r_sr[j] <= w_r >> 1;
            end
        end
    end

    assign o_radius = r_sr[SQRT_STEPS-1][31:0];

endmodule
`default_nettype wire

FILE: hdl/bmg_trig.sv
`default_nettype none
module bmg_trig
    import bmg_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic [UNIFORM_BITS-1:0] i_code,
    output t_trig                        o_trig
);

    logic [31:0] w_phase;
    logic [29:0] w_f;
    logic [61:0] r_xp;
    logic [29:0] r_xd  [14];
    logic [29:0] r_x2d [13];
    logic [2:0]  r_octd[TRIG_LAT];
    logic [59:0] w_xx;

    assign w_phase = 32'(i_code) << (32 - UNIFORM_BITS);
    assign w_f = w_phase[29] ? (30'd1 << 29) - {1'b0, w_phase[28:0]} : {1'b0, w_phase[28:0]};
    assign w_xx = 60'(r_xd[0]) * 60'(r_xd[0]);

    always_ff @(posedge i_clk) begin
        r_xp      <= 62'(w_f) * 62'(PI_Q30);
        r_octd[0] <= w_phase[31:29];
        r_xd[0]   <= 30'((r_xp + 62'(Q30_ONE)) >> 31);
        r_x2d[0]  <= 30'(w_xx >> 30);
        for (int s = 1; s < TRIG_LAT; s++) r_octd[s] <= r_octd[s-1];
        for (int s = 1; s < 14; s++) r_xd[s] <= r_xd[s-1];
        for (int s = 1; s < 13; s++) r_x2d[s] <= r_x2d[s-1];
    end

    // Horner steps: product, reciprocal multiply, correct and subtract
    logic [30:0] r_pc [5];
    logic [31:0] r_qc [5];
    logic [30:0] r_vc [5];
    logic [30:0] r_tc [5];
    logic [30:0] r_ps [4];
    logic [31:0] r_qs [4];
    logic [30:0] r_vs [4];
    logic [30:0] r_ts [4];

    for (genvar k = 0; k < 5; k++) begin : g_cos
        logic [30:0] w_t;
        logic [60:0] w_pr;
        logic [62:0] w_qm;
        logic [38:0] w_rem;
        logic [31:0] w_q;
        assign w_t   = (k == 0) ? 31'(Q30_ONE) : r_tc[(k == 0) ? 0 : k-1];
        assign w_pr  = 61'(r_x2d[3*k]) * 61'(w_t);
        assign w_qm  = 63'(r_pc[k]) * 63'(COS_RCP[k]);
        assign w_rem = 39'(r_vc[k]) - 39'(r_qc[k]) * 39'(COS_DIV[k]);
        assign w_q   = (w_rem >= 39'(COS_DIV[k])) ? r_qc[k] + 32'd1 : r_qc[k];
        always_ff @(posedge i_clk) begin
            r_pc[k] <= 31'(w_pr >> 30);
            r_qc[k] <= 32'(w_qm >> 32);
            r_vc[k] <= r_pc[k];
            r_tc[k] <= 31'(32'(Q30_ONE) - w_q);
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_sin
        logic [30:0] w_t;
        logic [60:0] w_pr;
        logic [62:0] w_qm;
        logic [38:0] w_rem;
        logic [31:0] w_q;
        assign w_t   = (k == 0) ? 31'(Q30_ONE) : r_ts[(k == 0) ? 0 : k-1];
        assign w_pr  = 61'(r_x2d[3*k]) * 61'(w_t);
        assign w_qm  = 63'(r_ps[k]) * 63'(SIN_RCP[k]);
        assign w_rem = 39'(r_vs[k]) - 39'(r_qs[k]) * 39'(SIN_DIV[k]);
        assign w_q   = (w_rem >= 39'(SIN_DIV[k])) ? r_qs[k] + 32'd1 : r_qs[k];
        always_ff @(posedge i_clk) begin
            r_ps[k] <= 31'(w_pr >> 30);
            r_qs[k] <= 32'(w_qm >> 32);
            r_vs[k] <= r_ps[k];
            r_ts[k] <= 31'(32'(Q30_ONE) - w_q);
        end
    end

    logic [60:0] w_sp;
    logic [30:0] r_sp [3];
    assign w_sp = 61'(r_xd[13]) * 61'(r_ts[3]);

    always_ff @(posedge i_clk) begin
        r_sp[0] <= 31'(w_sp >> 30);
        r_sp[1] <= r_sp[0];
        r_sp[2] <= r_sp[1];
    end

    // octant symmetry
    logic [2:0] w_oct;
    logic [2:0] w_oi;
    assign w_oct = r_octd[TRIG_LAT-1];
    assign w_oi  = w_oct + 3'd1;

    always_comb begin
        if (w_oi[1]) begin
            o_trig.tc = r_sp[2];
            o_trig.ts = r_tc[4];
        end else begin
            o_trig.tc = r_tc[4];
            o_trig.ts = r_sp[2];
        end
        o_trig.negc = (w_oct >= 3'd2) && (w_oct <= 3'd5);
        o_trig.negs = w_oct[2];
    end

endmodule
`default_nettype wire
